// ===== src/tmcs_pkg.sv =====
// ----------------------------------------------------------------------------
// tmcs_pkg
// Types and constants shared by the timed motor cycle sequencer modules.
// ----------------------------------------------------------------------------
package tmcs_pkg;

    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_WAIT = 4'b0010,
        PH_FWD  = 4'b0100,
        PH_REV  = 4'b1000
    } t_phase;

    localparam logic [1:0] PC_IDLE = 2'd0;
    localparam logic [1:0] PC_WAIT = 2'd1;
    localparam logic [1:0] PC_FWD  = 2'd2;
    localparam logic [1:0] PC_REV  = 2'd3;

    localparam logic [1:0] CFG_DELAY_SECONDS = 2'd0;
    localparam logic [1:0] CFG_FORWARD_MS    = 2'd1;
    localparam logic [1:0] CFG_CYCLE_TOTAL   = 2'd2;
    localparam logic [1:0] CFG_DEBOUNCE_MS   = 2'd3;

    localparam logic [6:0]  DELAY_SECONDS_RST = 7'd0;
    localparam logic [15:0] FORWARD_MS_RST    = 16'd3000;
    localparam logic [3:0]  CYCLE_TOTAL_RST   = 4'd4;
    localparam logic [15:0] DEBOUNCE_MS_RST   = 16'd200;

    localparam logic [15:0] MS_PER_SECOND = 16'd1000;
    localparam logic [15:0] MS_SAT        = 16'hFFFF;
    localparam logic [6:0]  SEC_SAT       = 7'd127;

    typedef struct packed {
        logic [6:0]  delay_seconds;
        logic [15:0] forward_ms;
        logic [3:0]  cycle_total;
        logic [15:0] debounce_ms;
    } t_cfg;

    typedef struct packed {
        logic tick;
        logic switch1_edge;
        logic switch2_pressed;
        logic abort;
    } t_in;

    typedef struct packed {
        t_phase      phase;
        logic [3:0]  cycle_index;
        logic [15:0] millis_in_phase;
        logic [6:0]  seconds_in_phase;
        logic        running_flag;
        logic [15:0] since_last_edge;
        logic [15:0] reverse_count;
    } t_state;

    typedef struct packed {
        logic [15:0] reverse_total;
        logic        is_running;
        logic [3:0]  cycle_number;
        logic [1:0]  phase_code;
        logic        relay_on;
        logic        drive_reverse;
        logic        drive_forward;
    } t_out;

    localparam t_state STATE_RST = '{
        phase:            PH_IDLE,
        cycle_index:      4'd0,
        millis_in_phase:  16'd0,
        seconds_in_phase: 7'd0,
        running_flag:     1'b0,
        since_last_edge:  16'hFFFF,
        reverse_count:    16'd0
    };

endpackage

// ===== src/tmcs_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// tmcs_cfg_regs
// Configuration register file of the sequencer.
// ----------------------------------------------------------------------------
module tmcs_cfg_regs
    import tmcs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_wr_en,
    input  logic [1:0]  i_wr_addr,
    input  logic [15:0] i_wr_data,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr_en) begin
            case (i_wr_addr)
                CFG_DELAY_SECONDS: n_cfg.delay_seconds = i_wr_data[6:0];
                CFG_FORWARD_MS:    n_cfg.forward_ms    = i_wr_data;
                CFG_CYCLE_TOTAL:   n_cfg.cycle_total   = i_wr_data[3:0];
                CFG_DEBOUNCE_MS:   n_cfg.debounce_ms   = i_wr_data;
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.delay_seconds <= DELAY_SECONDS_RST;
            r_cfg.forward_ms    <= FORWARD_MS_RST;
            r_cfg.cycle_total   <= CYCLE_TOTAL_RST;
            r_cfg.debounce_ms   <= DEBOUNCE_MS_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== src/tmcs_step.sv =====
// ----------------------------------------------------------------------------
// tmcs_step
// Next-state and result logic for one item of the sequencer.
// ----------------------------------------------------------------------------
module tmcs_step
    import tmcs_pkg::*;
(
    input  t_cfg   i_cfg,
    input  t_state i_state,
    input  t_in    i_item,
    output t_state o_state,
    output t_out   o_result
);

    logic [3:0]  w_total;
    logic [3:0]  w_next_cycle;
    logic [15:0] w_millis_inc;
    t_state      s;

    assign w_total = (i_cfg.cycle_total == 4'd0) ? 4'd1 : i_cfg.cycle_total;

    always_comb begin
        s = i_state;
        w_next_cycle = i_state.cycle_index + 4'd1;
        w_millis_inc = i_state.millis_in_phase + 16'd1;
        if (i_item.abort) begin
            s = STATE_RST;
        end else begin
            if (i_item.switch1_edge) begin
                if (i_state.since_last_edge > i_cfg.debounce_ms) begin
                    s.running_flag = !i_state.running_flag;
                    if (!i_state.running_flag) begin
                        s.millis_in_phase  = 16'd0;
                        s.seconds_in_phase = 7'd0;
                    end
                end
                s.since_last_edge = 16'd0;
            end else if (i_item.tick && (i_state.since_last_edge != MS_SAT)) begin
                s.since_last_edge = i_state.since_last_edge + 16'd1;
            end

            w_millis_inc = s.millis_in_phase + 16'd1;

            case (i_state.phase)
                PH_IDLE: begin
                    if (s.running_flag) begin
                        s.phase            = PH_WAIT;
                        s.cycle_index      = 4'd0;
                        s.millis_in_phase  = 16'd0;
                        s.seconds_in_phase = 7'd0;
                    end
                end
                PH_WAIT: begin
                    if (s.running_flag) begin
                        if (i_item.tick) begin
                            s.millis_in_phase = w_millis_inc;
                            if (w_millis_inc >= MS_PER_SECOND) begin
                                s.millis_in_phase = 16'd0;
                                if (s.seconds_in_phase < SEC_SAT) begin
                                    s.seconds_in_phase = s.seconds_in_phase + 7'd1;
                                end
                            end
                        end
                        if (s.seconds_in_phase >= i_cfg.delay_seconds) begin
                            s.phase            = PH_FWD;
                            s.millis_in_phase  = 16'd0;
                            s.seconds_in_phase = 7'd0;
                        end
                    end
                end
                PH_FWD: begin
                    if (s.running_flag) begin
                        if (i_item.tick && (s.millis_in_phase != MS_SAT)) begin
                            s.millis_in_phase = w_millis_inc;
                        end
                        if (s.millis_in_phase >= i_cfg.forward_ms) begin
                            s.cycle_index      = w_next_cycle;
                            s.phase            = (w_next_cycle >= w_total) ? PH_REV : PH_WAIT;
                            s.millis_in_phase  = 16'd0;
                            s.seconds_in_phase = 7'd0;
                        end
                    end
                end
                PH_REV: begin
                    if (i_item.switch2_pressed) begin
                        s.reverse_count    = i_state.reverse_count + 16'd1;
                        s.cycle_index      = 4'd0;
                        s.millis_in_phase  = 16'd0;
                        s.seconds_in_phase = 7'd0;
                        s.phase            = s.running_flag ? PH_WAIT : PH_IDLE;
                    end
                end
                default: begin
                    s = STATE_RST;
                end
            endcase
        end
    end

    always_comb begin
        o_result               = '0;
        o_result.is_running    = s.running_flag;
        o_result.reverse_total = s.reverse_count;
        case (s.phase)
            PH_WAIT: begin
                o_result.phase_code   = PC_WAIT;
                o_result.cycle_number = s.cycle_index + 4'd1;
                o_result.relay_on     = s.running_flag;
            end
            PH_FWD: begin
                o_result.phase_code    = PC_FWD;
                o_result.cycle_number  = s.cycle_index + 4'd1;
                o_result.relay_on      = s.running_flag;
                o_result.drive_forward = s.running_flag;
            end
            PH_REV: begin
                o_result.phase_code    = PC_REV;
                o_result.cycle_number  = s.cycle_index;
                o_result.drive_reverse = 1'b1;
            end
            default: begin
                o_result.phase_code   = PC_IDLE;
                o_result.cycle_number = 4'd0;
            end
        endcase
    end

    assign o_state = s;

endmodule

// ===== src/timed_motor_cycle_sequencer_unit.sv =====
// ----------------------------------------------------------------------------
// timed_motor_cycle_sequencer_unit
// Wait, forward and reverse motor cycle sequencer with pause and abort.
// ----------------------------------------------------------------------------
// Channel   Direction  Payload
// s_axis    in         tdata[3:0]: tick, switch1_edge, switch2_pressed, abort
// m_axis    out        tdata[25:0]: motor controls, phase, cycle, count
// cfg       in         addr[1:0] register index, data[15:0] value
//
// One item per clock unless the output stalls: an input register feeds the
// step logic, which updates the sequencer state and loads the result register
// in the same cycle. Items go from the input register into the result one.
// A stalled result holds; the input register still takes one more item.
// Reset is synchronous, active low; it resets state, not item or result registers.
// ----------------------------------------------------------------------------
module timed_motor_cycle_sequencer_unit
    import tmcs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // tick, switch1_edge, switch2_pressed, abort (bits 0 to 3), zeros above
    input  logic [7:0]  i_s_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // drive_forward, drive_reverse, relay_on, phase_code[1:0], cycle_number[3:0],
    // is_running, reverse_total[15:0] from bit 0 up, zeros above
    output logic [31:0] o_m_axis_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_addr,
    input  logic [15:0] i_cfg_data
);

    t_cfg   w_cfg;
    t_state r_state;
    t_state w_state_next;
    t_out   w_result;
    t_out   r_result;
    t_in    r_item;
    logic   r_in_valid;
    logic   r_out_valid;
    logic   w_out_free;
    logic   w_fire;
    logic   w_in_accept;

    assign o_cfg_ready = 1'b1;

    tmcs_cfg_regs u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (i_cfg_valid),
        .i_wr_addr (i_cfg_addr),
        .i_wr_data (i_cfg_data),
        .o_cfg     (w_cfg)
    );

    tmcs_step u_step (
        .i_cfg    (w_cfg),
        .i_state  (r_state),
        .i_item   (r_item),
        .o_state  (w_state_next),
        .o_result (w_result)
    );

    assign w_out_free      = !r_out_valid || i_m_axis_tready;
    assign w_fire          = r_in_valid && w_out_free;
    assign o_s_axis_tready = !r_in_valid || w_out_free;
    assign w_in_accept     = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= STATE_RST;
        end else begin
            if (w_in_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_fire) begin
                r_in_valid <= 1'b0;
            end
            if (w_fire) begin
                r_out_valid <= 1'b1;
                r_state     <= w_state_next;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_item.tick            <= i_s_axis_tdata[0];
            r_item.switch1_edge    <= i_s_axis_tdata[1];
            r_item.switch2_pressed <= i_s_axis_tdata[2];
            r_item.abort           <= i_s_axis_tdata[3];
        end
        if (w_fire) begin
            r_result <= w_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'd0, r_result};

endmodule

// ===== src/tmcs_checker.sv =====
// ----------------------------------------------------------------------------
// tmcs_checker
// Port-level checks on the sequencer and the bind that attaches them.
// ----------------------------------------------------------------------------
module tmcs_checker
    import tmcs_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [31:0] o_m_axis_tdata
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("Stalled result item changed or dropped.");

    a_fwd_needs_relay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[0] |-> o_m_axis_tdata[2] && o_m_axis_tdata[9])
        else $error("Forward drive without relay or while paused.");

    a_one_direction: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !(o_m_axis_tdata[0] && o_m_axis_tdata[1]))
        else $error("Forward and reverse driven together.");

    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tdata[4:3] == PC_IDLE)
        |-> (o_m_axis_tdata[8:5] == 4'd0) && (o_m_axis_tdata[2:0] == 3'd0))
        else $error("Idle phase shows a cycle number or an active output.");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("Result valid right after reset.");

endmodule

bind timed_motor_cycle_sequencer_unit tmcs_checker u_tmcs_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the timed motor cycle sequencer. A short table of
// directed items runs first, then randomized phases under several register
// settings. Results are checked against typed rows or an in-bench prediction
// of the sequencer state, with random gaps on input and stalls on output.
// ----------------------------------------------------------------------------
module tb_top;
    import tmcs_pkg::*;

    localparam logic [3:0] ITM_NONE  = 4'b0000;
    localparam logic [3:0] ITM_TICK  = 4'b0001;
    localparam logic [3:0] ITM_EDGE  = 4'b0010;
    localparam logic [3:0] ITM_SW2   = 4'b0100;
    localparam logic [3:0] ITM_ABORT = 4'b1000;

    typedef struct packed {
        logic abort;
        logic switch2_pressed;
        logic switch1_edge;
        logic tick;
    } t_sensor_item;

    typedef struct packed {
        logic [3:0] bits;
        logic       has_typed;
        t_out       result;
    } t_row;

    localparam t_out OUT_IDLE = '0;
    localparam t_out OUT_STARTED = '{
        reverse_total: 16'd0,
        is_running:    1'b1,
        cycle_number:  4'd1,
        phase_code:    PC_WAIT,
        relay_on:      1'b1,
        drive_reverse: 1'b0,
        drive_forward: 1'b0
    };

    localparam t_row DIRECTED_ROWS [12] = '{
        '{ITM_NONE, 1'b1, OUT_IDLE},
        '{ITM_TICK | ITM_EDGE | ITM_SW2 | ITM_ABORT, 1'b1, OUT_IDLE},
        '{ITM_EDGE, 1'b1, OUT_STARTED},
        '{ITM_EDGE | ITM_TICK, 1'b0, OUT_IDLE},
        '{ITM_TICK, 1'b0, OUT_IDLE},
        '{ITM_TICK | ITM_SW2, 1'b0, OUT_IDLE},
        '{ITM_ABORT, 1'b1, OUT_IDLE},
        '{ITM_TICK | ITM_SW2, 1'b1, OUT_IDLE},
        '{ITM_EDGE, 1'b1, OUT_STARTED},
        '{ITM_TICK, 1'b0, OUT_IDLE},
        '{ITM_EDGE, 1'b0, OUT_IDLE},
        '{ITM_ABORT | ITM_EDGE | ITM_TICK, 1'b1, OUT_IDLE}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    // tick, switch1_edge, switch2_pressed, abort from bit 0 up, zeros above
    logic [7:0]  i_s_axis_tdata = 8'h00;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    // drive_forward, drive_reverse, relay_on, phase_code, cycle_number,
    // is_running, reverse_total from bit 0 up, zeros above
    logic [31:0] o_m_axis_tdata;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_addr = 2'd0;
    logic [15:0] i_cfg_data = 16'd0;

    logic [6:0]  cfg_delay_s     = DELAY_SECONDS_RST;
    logic [15:0] cfg_forward_ms  = FORWARD_MS_RST;
    logic [3:0]  cfg_cycle_total = CYCLE_TOTAL_RST;
    logic [15:0] cfg_debounce_ms = DEBOUNCE_MS_RST;

    logic [1:0]  seq_phase;
    logic [3:0]  seq_cycle;
    logic [15:0] seq_ms;
    logic [6:0]  seq_sec;
    logic        seq_running;
    logic [15:0] seq_since_edge;
    logic [15:0] seq_reversals;

    t_out expected_outputs [$];
    t_out observed;
    t_out wanted;
    int   mismatch_count = 0;
    int   gapless_left = 0;
    int   stall_left = 0;
    int   ready_streak = 0;
    int   ready_roll;

    timed_motor_cycle_sequencer_unit u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic void clear_sequencer();
        seq_phase      = PC_IDLE;
        seq_cycle      = '0;
        seq_ms         = '0;
        seq_sec        = '0;
        seq_running    = 1'b0;
        seq_since_edge = MS_SAT;
        seq_reversals  = '0;
    endfunction

    function automatic t_out sequencer_step(input t_sensor_item it);
        t_out       res;
        logic [3:0] cycles_eff;
        cycles_eff = (cfg_cycle_total == 4'd0) ? 4'd1 : cfg_cycle_total;
        if (it.abort) begin
            clear_sequencer();
        end else begin
            if (it.switch1_edge) begin
                if (seq_since_edge > cfg_debounce_ms) begin
                    seq_running = !seq_running;
                    if (seq_running) begin
                        seq_ms  = '0;
                        seq_sec = '0;
                    end
                end
                seq_since_edge = '0;
            end else if (it.tick && seq_since_edge != MS_SAT) begin
                seq_since_edge++;
            end
            case (seq_phase)
                PC_IDLE: begin
                    if (seq_running) begin
                        seq_phase = PC_WAIT;
                        seq_cycle = '0;
                        seq_ms    = '0;
                        seq_sec   = '0;
                    end
                end
                PC_WAIT: begin
                    if (seq_running) begin
                        if (it.tick) begin
                            seq_ms++;
                            if (seq_ms >= MS_PER_SECOND) begin
                                seq_ms = '0;
                                if (seq_sec != SEC_SAT) seq_sec++;
                            end
                        end
                        if (seq_sec >= cfg_delay_s) begin
                            seq_phase = PC_FWD;
                            seq_ms    = '0;
                            seq_sec   = '0;
                        end
                    end
                end
                PC_FWD: begin
                    if (seq_running) begin
                        if (it.tick && seq_ms != MS_SAT) seq_ms++;
                        if (seq_ms >= cfg_forward_ms) begin
                            seq_cycle++;
                            seq_phase = (seq_cycle >= cycles_eff) ? PC_REV : PC_WAIT;
                            seq_ms    = '0;
                            seq_sec   = '0;
                        end
                    end
                end
                default: begin
                    if (it.switch2_pressed) begin
                        seq_reversals++;
                        seq_cycle = '0;
                        seq_ms    = '0;
                        seq_sec   = '0;
                        seq_phase = seq_running ? PC_WAIT : PC_IDLE;
                    end
                end
            endcase
        end
        res = '0;
        res.phase_code    = seq_phase;
        res.drive_forward = (seq_phase == PC_FWD) && seq_running;
        res.drive_reverse = (seq_phase == PC_REV);
        res.relay_on      = (seq_phase == PC_WAIT || seq_phase == PC_FWD) && seq_running;
        res.is_running    = seq_running;
        res.reverse_total = seq_reversals;
        if (seq_phase == PC_WAIT || seq_phase == PC_FWD) begin
            res.cycle_number = seq_cycle + 4'd1;
        end else if (seq_phase == PC_REV) begin
            res.cycle_number = seq_cycle;
        end
        return res;
    endfunction

    function automatic int pick_item_gap();
        int roll;
        if (gapless_left > 0) begin
            gapless_left--;
            return 0;
        end
        roll = $urandom_range(999);
        if (roll < 10) begin
            gapless_left = $urandom_range(20, 80);
            return 0;
        end
        if (roll < 700) return 0;
        if (roll < 950) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [3:0] random_item(input int tick_pm, input int edge_pm,
                                               input int sw2_pm, input int abort_pm);
        t_sensor_item it;
        it.tick            = ($urandom_range(999) < tick_pm);
        it.switch1_edge    = ($urandom_range(999) < edge_pm);
        it.switch2_pressed = ($urandom_range(999) < sw2_pm);
        it.abort           = ($urandom_range(999) < abort_pm);
        return it;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int exp_val);
        mismatch_count++;
        if (mismatch_count <= 100) begin
            $display("%0t: %s got %0d expected %0d", $time, what, got, exp_val);
        end
    endtask

    task automatic send_item(input logic [3:0] bits, input logic has_typed,
                             input t_out typed_result);
        int   gap;
        t_out predicted;
        gap = pick_item_gap();
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {4'b0000, bits};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        predicted = sequencer_step(t_sensor_item'(bits));
        expected_outputs.push_back(has_typed ? typed_result : predicted);
    endtask

    task automatic write_config(input logic [6:0] delay_s, input logic [15:0] forward_ms,
                                input logic [3:0] cycle_total, input logic [15:0] debounce_ms);
        logic [15:0] values [4];
        values[CFG_DELAY_SECONDS] = {9'd0, delay_s};
        values[CFG_FORWARD_MS]    = forward_ms;
        values[CFG_CYCLE_TOTAL]   = {12'd0, cycle_total};
        values[CFG_DEBOUNCE_MS]   = debounce_ms;
        while (expected_outputs.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        for (int k = 0; k < 4; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_addr  <= 2'(k);
            i_cfg_data  <= values[k];
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
        end
        i_cfg_valid     <= 1'b0;
        cfg_delay_s     = delay_s;
        cfg_forward_ms  = forward_ms;
        cfg_cycle_total = cycle_total;
        cfg_debounce_ms = debounce_ms;
    endtask

    task automatic run_phase(input logic restart, input logic [6:0] delay_s,
                             input logic [15:0] forward_ms, input logic [3:0] cycle_total,
                             input logic [15:0] debounce_ms, input int n_items,
                             input int tick_pm, input int edge_pm, input int sw2_pm,
                             input int abort_pm);
        write_config(delay_s, forward_ms, cycle_total, debounce_ms);
        if (restart) begin
            send_item(ITM_ABORT, 1'b0, OUT_IDLE);
            send_item(ITM_EDGE, 1'b0, OUT_IDLE);
        end
        for (int k = 0; k < n_items; k++) begin
            send_item(random_item(tick_pm, edge_pm, sw2_pm, abort_pm), 1'b0, OUT_IDLE);
        end
        i_s_axis_tvalid <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            i_m_axis_tready <= 1'b0;
            stall_left--;
        end else if (ready_streak > 0) begin
            i_m_axis_tready <= 1'b1;
            ready_streak--;
        end else begin
            ready_roll = $urandom_range(999);
            if (ready_roll < 10) begin
                i_m_axis_tready <= 1'b1;
                ready_streak = $urandom_range(30, 150);
            end else if (ready_roll < 130) begin
                i_m_axis_tready <= 1'b0;
                stall_left = $urandom_range(0, 2);
            end else if (ready_roll < 160) begin
                i_m_axis_tready <= 1'b0;
                stall_left = $urandom_range(9, 39);
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            observed = t_out'(o_m_axis_tdata[25:0]);
            if (expected_outputs.size() == 0) begin
                report_mismatch("result with nothing expected", int'(observed), 0);
            end else begin
                wanted = expected_outputs.pop_front();
                if (observed.drive_forward !== wanted.drive_forward)
                    report_mismatch("drive_forward", observed.drive_forward,
                                    wanted.drive_forward);
                if (observed.drive_reverse !== wanted.drive_reverse)
                    report_mismatch("drive_reverse", observed.drive_reverse,
                                    wanted.drive_reverse);
                if (observed.relay_on !== wanted.relay_on)
                    report_mismatch("relay_on", observed.relay_on, wanted.relay_on);
                if (observed.phase_code !== wanted.phase_code)
                    report_mismatch("phase_code", observed.phase_code, wanted.phase_code);
                if (observed.cycle_number !== wanted.cycle_number)
                    report_mismatch("cycle_number", observed.cycle_number,
                                    wanted.cycle_number);
                if (observed.is_running !== wanted.is_running)
                    report_mismatch("is_running", observed.is_running, wanted.is_running);
                if (observed.reverse_total !== wanted.reverse_total)
                    report_mismatch("reverse_total", observed.reverse_total,
                                    wanted.reverse_total);
            end
        end
    end

    initial begin
        clear_sequencer();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < 12; k++) begin
            send_item(DIRECTED_ROWS[k].bits, DIRECTED_ROWS[k].has_typed,
                      DIRECTED_ROWS[k].result);
        end
        i_s_axis_tvalid <= 1'b0;

        run_phase(1'b0, 7'd0, 16'($urandom_range(1, 12)), 4'($urandom_range(1, 4)),
                  16'($urandom_range(0, 8)), 160, 750, 40, 150, 5);
        run_phase(1'b0, 7'd0, 16'd0, 4'd0, 16'd0, 110, 750, 40, 150, 5);
        // A full one-second wait needs a thousand ticks without a pause.
        run_phase(1'b1, 7'd1, 16'd4, 4'd1, 16'd50, 1050, 1000, 0, 200, 0);
        run_phase(1'b1, 7'd99, 16'hFFFF, 4'd15, 16'hFFFF, 50, 750, 40, 150, 5);
        run_phase(1'b1, 7'd0, 16'd2, 4'd15, 16'd3, 90, 750, 40, 150, 5);

        while (expected_outputs.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/tmcs_pkg.sv
src/tmcs_cfg_regs.sv
src/tmcs_step.sv
src/timed_motor_cycle_sequencer_unit.sv
src/tmcs_checker.sv
dv/tb_top.sv
